FILE: sv/nalscan_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Annex B NAL unit scanner.
// No dependencies; imported by every module of the block.
package nalscan_pkg;

  // NAL unit types of interest
  localparam logic [4:0] TYPE_SLICE = 5'd1;
  localparam logic [4:0] TYPE_IDR   = 5'd5;
  localparam logic [4:0] TYPE_SEI   = 5'd6;
  localparam logic [4:0] TYPE_SPS   = 5'd7;
  localparam logic [4:0] TYPE_PPS   = 5'd8;

  // unit_class codes
  localparam logic [1:0] CLASS_PARAM_SET = 2'd0;
  localparam logic [1:0] CLASS_SEI       = 2'd1;
  localparam logic [1:0] CLASS_OTHER     = 2'd2;

  // record_kind codes
  localparam logic KIND_UNIT    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [1:0] ZERO_RUN_MAX = 2'd3;
  localparam logic [7:0] START_BYTE   = 8'h01;
  localparam logic [7:0] ZERO_BYTE    = 8'h00;

  localparam int RESULT_QUEUE_DEPTH = 4;
  localparam int RESULT_QUEUE_AW    = $clog2(RESULT_QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic [1:0] initial_priority;
  } scan_in_t;

  typedef struct packed {
    logic        record_kind;
    logic [4:0]  unit_type;
    logic [1:0]  ref_importance;
    logic [1:0]  unit_class;
    logic [23:0] unit_length;
    logic [1:0]  packet_priority;
    logic        any_idr_seen;
    logic        first_slice_idr;
    logic        last_result;
  } scan_out_t;

  // running state of the scanner, apart from the length counter
  typedef struct packed {
    logic [1:0] zero_run;
    logic       unit_open;
    logic       await_header;
    logic [7:0] current_header;
    logic [1:0] running_priority;
    logic       idr_flag;
    logic       slice_decided;
    logic       slice_was_idr;
    logic       packet_begun;
  } scan_state_t;

  function automatic logic [1:0] class_of(input logic [4:0] unit_type);
    logic [1:0] cls;
    if (unit_type == TYPE_SPS || unit_type == TYPE_PPS) begin
      cls = CLASS_PARAM_SET;
    end else if (unit_type == TYPE_SEI) begin
      cls = CLASS_SEI;
    end else begin
      cls = CLASS_OTHER;
    end
    return cls;
  endfunction

endpackage

FILE: sv/annexb_nal_scanner_core.sv
`timescale 1ns / 1ps
// Annex B NAL unit scanner, top level. Takes one packet byte per item and
// emits unit records and a packet summary. Depends on nalscan_pkg,
// nalscan_step and nalscan_queue.
//
// Usage: the block takes one byte per cycle. A byte updates the scanner
// state in the same cycle it is accepted and gives zero, one or two result
// records, which wait in a four-entry queue. A byte is taken while the queue
// has room for two records, so the input stalls only when the result side
// stalls or when bytes that close a unit at the end of a packet come faster
// than one record per cycle can drain. Results are written to the queue at the
// edge that accepts their byte. LENGTH_BITS sets the width of the unit length
// counter, which saturates at its maximum; unit_length shows its low 24 bits.
module annexb_nal_scanner_core #(
  parameter int LENGTH_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_stall,
  input  nalscan_pkg::scan_in_t  byte_item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output nalscan_pkg::scan_out_t result_item
);
  import nalscan_pkg::*;

  scan_state_t            state;
  scan_state_t            state_next;
  logic [LENGTH_BITS-1:0] length_count;
  logic [LENGTH_BITS-1:0] length_count_next;
  scan_out_t              step_first;
  scan_out_t              step_second;
  logic [1:0]             step_count;
  logic [1:0]             push_count;
  logic                   room;
  logic                   accept;

  assign byte_stall = !room;
  assign accept     = byte_valid && room;
  assign push_count = accept ? step_count : 2'd0;

  nalscan_step #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_step (
    .item              (byte_item),
    .state             (state),
    .length_count      (length_count),
    .state_next        (state_next),
    .length_count_next (length_count_next),
    .result_first      (step_first),
    .result_second     (step_second),
    .result_count      (step_count)
  );

  nalscan_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push_count  (push_count),
    .push_first  (step_first),
    .push_second (step_second),
    .room        (room),
    .valid       (result_valid),
    .stall       (result_stall),
    .item        (result_item)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= '0;
      length_count <= '0;
    end else if (accept) begin
      state        <= state_next;
      length_count <= length_count_next;
    end
  end

endmodule

FILE: sv/nalscan_step.sv
`timescale 1ns / 1ps
// Per-byte next-state logic of the NAL unit scanner: start code detection,
// length counting, summary tracking and up to two result records.
// Depends on nalscan_pkg.
module nalscan_step #(
  parameter int LENGTH_BITS = 24
) (
  input  nalscan_pkg::scan_in_t    item,
  input  nalscan_pkg::scan_state_t state,
  input  logic [LENGTH_BITS-1:0]   length_count,
  output nalscan_pkg::scan_state_t state_next,
  output logic [LENGTH_BITS-1:0]   length_count_next,
  output nalscan_pkg::scan_out_t   result_first,
  output nalscan_pkg::scan_out_t   result_second,
  output logic [1:0]               result_count
);
  import nalscan_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  function automatic logic [LENGTH_BITS-1:0] sat_add(input logic [LENGTH_BITS-1:0] a,
                                                     input logic [2:0] b);
    logic [LENGTH_BITS:0] sum;
    sum = {1'b0, a} + (LENGTH_BITS+1)'(b);
    return sum[LENGTH_BITS] ? LEN_MAX : sum[LENGTH_BITS-1:0];
  endfunction

  function automatic scan_out_t unit_record(input logic [7:0] header,
                                            input logic [LENGTH_BITS-1:0] len);
    scan_out_t rec;
    rec                = '0;
    rec.record_kind    = KIND_UNIT;
    rec.unit_type      = header[4:0];
    rec.ref_importance = header[6:5];
    rec.unit_class     = class_of(header[4:0]);
    rec.unit_length    = 24'(len);
    return rec;
  endfunction

  scan_state_t            s;
  logic [LENGTH_BITS-1:0] len;
  scan_out_t              summary;
  scan_out_t              closing;
  logic                   start_unit_emit;
  logic [4:0]             hdr_type;

  always_comb begin
    s                = state;
    len              = length_count;
    start_unit_emit  = 1'b0;
    result_first     = '0;
    result_second    = '0;
    result_count     = 2'd0;
    hdr_type         = item.data_byte[4:0];

    // first byte of a packet: start from a clean slate
    if (!state.packet_begun) begin
      s                  = '0;
      s.running_priority = item.initial_priority;
      s.packet_begun     = 1'b1;
      len                = '0;
    end

    closing = unit_record(s.current_header, len);

    if (s.await_header) begin
      s.await_header   = 1'b0;
      s.unit_open      = 1'b1;
      s.current_header = item.data_byte;
      if (item.data_byte == ZERO_BYTE) begin
        len        = '0;
        s.zero_run = 2'd1;
      end else begin
        len        = LENGTH_BITS'(1);
        s.zero_run = 2'd0;
      end
      if (item.data_byte[6:5] > s.running_priority) begin
        s.running_priority = item.data_byte[6:5];
      end
      if (hdr_type == TYPE_IDR) begin
        s.idr_flag = 1'b1;
      end
      if (!s.slice_decided && (hdr_type inside {TYPE_IDR, TYPE_SLICE})) begin
        s.slice_decided = 1'b1;
        s.slice_was_idr = (hdr_type == TYPE_IDR);
      end
    end else if (item.data_byte == ZERO_BYTE) begin
      if (s.zero_run != ZERO_RUN_MAX) begin
        s.zero_run = s.zero_run + 2'd1;
      end else if (s.unit_open) begin
        len = sat_add(len, 3'd1);
      end
    end else if (item.data_byte == START_BYTE && s.zero_run >= 2'd2) begin
      // start code closes the open unit; its zeros are not counted
      start_unit_emit = s.unit_open;
      s.unit_open     = 1'b0;
      s.await_header  = 1'b1;
      s.zero_run      = 2'd0;
    end else begin
      if (s.unit_open) begin
        len = sat_add(len, {1'b0, s.zero_run} + 3'd1);
      end
      s.zero_run = 2'd0;
    end

    summary                 = '0;
    summary.record_kind     = KIND_SUMMARY;
    summary.packet_priority = s.running_priority;
    summary.any_idr_seen    = s.idr_flag;
    summary.first_slice_idr = s.slice_was_idr;
    summary.last_result     = 1'b1;

    if (start_unit_emit) begin
      result_first = closing;
      result_count = 2'd1;
    end

    if (item.last_byte) begin
      // end of packet: trailing zeros belong to the open unit
      if (s.unit_open) begin
        result_first  = unit_record(s.current_header, sat_add(len, {1'b0, s.zero_run}));
        result_second = summary;
        result_count  = 2'd2;
      end else if (start_unit_emit) begin
        result_second = summary;
        result_count  = 2'd2;
      end else begin
        result_first = summary;
        result_count = 2'd1;
      end
      s.packet_begun = 1'b0;
      s.unit_open    = 1'b0;
      s.await_header = 1'b0;
      s.zero_run     = 2'd0;
      len            = '0;
    end else if (start_unit_emit) begin
      result_first.last_result = 1'b1;
    end

    state_next        = s;
    length_count_next = len;
  end

endmodule

FILE: sv/nalscan_queue.sv
`timescale 1ns / 1ps
// Small result queue: takes up to two records per cycle, hands out one.
// Depends on nalscan_pkg.
module nalscan_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [1:0]             push_count,
  input  nalscan_pkg::scan_out_t push_first,
  input  nalscan_pkg::scan_out_t push_second,
  output logic                   room,
  output logic                   valid,
  input  logic                   stall,
  output nalscan_pkg::scan_out_t item
);
  import nalscan_pkg::*;

  localparam logic [RESULT_QUEUE_AW:0] ROOM_LIMIT = (RESULT_QUEUE_AW+1)'(RESULT_QUEUE_DEPTH - 2);

  scan_out_t                  entries [RESULT_QUEUE_DEPTH];
  logic [RESULT_QUEUE_AW-1:0] wr_ptr;
  logic [RESULT_QUEUE_AW-1:0] rd_ptr;
  logic [RESULT_QUEUE_AW:0]   count;
  logic [RESULT_QUEUE_AW-1:0] wr_ptr_second;
  logic                       pop;

  assign room          = (count <= ROOM_LIMIT);
  assign valid         = (count != '0);
  assign item          = entries[rd_ptr];
  assign pop           = valid && !stall;
  assign wr_ptr_second = wr_ptr + RESULT_QUEUE_AW'(1);

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr] <= push_first;
    end
    if (push_count == 2'd2) begin
      entries[wr_ptr_second] <= push_second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RESULT_QUEUE_AW'(push_count);
      if (pop) begin
        rd_ptr <= rd_ptr + RESULT_QUEUE_AW'(1);
      end
      count <= count + (RESULT_QUEUE_AW+1)'(push_count) - (RESULT_QUEUE_AW+1)'(pop);
    end
  end

endmodule

FILE: tb/nalscan_checker.sv
`timescale 1ns / 1ps
// Record checker for the Annex B NAL unit scanner: watches both channels,
// predicts unit and summary records per accepted byte, compares in order.
// Depends on nalscan_pkg.
module nalscan_checker #(
  parameter int LENGTH_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  input  logic                   byte_stall,
  input  nalscan_pkg::scan_in_t  byte_item,
  input  logic                   result_valid,
  input  logic                   result_stall,
  input  nalscan_pkg::scan_out_t result_item,
  output int                     mismatches,
  output int                     records_pending
);
  import nalscan_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LEN_CAP = '1;

  // predicted scanner state
  logic [1:0]             zeros_held = '0;
  logic                   unit_live = 1'b0;
  logic                   header_next = 1'b0;
  logic [7:0]             header_byte = '0;
  logic [LENGTH_BITS-1:0] unit_len = '0;
  logic [1:0]             prio_max = '0;
  logic                   idr_any = 1'b0;
  logic                   slice_known = 1'b0;
  logic                   slice_idr = 1'b0;
  logic                   in_packet = 1'b0;

  scan_out_t records_due[$];
  scan_out_t want;
  int        fail_tally = 0;

  assign mismatches = fail_tally;

  function automatic logic [LENGTH_BITS-1:0] len_plus(input logic [LENGTH_BITS-1:0] a,
                                                      input int unsigned b);
    logic [LENGTH_BITS:0] sum;
    sum = {1'b0, a} + (LENGTH_BITS+1)'(b);
    return (sum > {1'b0, LEN_CAP}) ? LEN_CAP : sum[LENGTH_BITS-1:0];
  endfunction

  function automatic scan_out_t unit_record(input logic [7:0] hdr,
                                            input logic [LENGTH_BITS-1:0] len);
    scan_out_t   r;
    logic [31:0] wide;
    r = '0;
    wide = 32'(len);
    r.record_kind    = KIND_UNIT;
    r.unit_type      = hdr[4:0];
    r.ref_importance = hdr[6:5];
    case (hdr[4:0])
      TYPE_SPS, TYPE_PPS: r.unit_class = CLASS_PARAM_SET;
      TYPE_SEI:           r.unit_class = CLASS_SEI;
      default:            r.unit_class = CLASS_OTHER;
    endcase
    r.unit_length = wide[23:0];
    return r;
  endfunction

  function automatic scan_out_t summary_record();
    scan_out_t r;
    r = '0;
    r.record_kind     = KIND_SUMMARY;
    r.packet_priority = prio_max;
    r.any_idr_seen    = idr_any;
    r.first_slice_idr = slice_idr;
    return r;
  endfunction

  // advance the predicted state by one byte and queue the records it closes
  task automatic scan_byte(input scan_in_t it);
    scan_out_t  recs [2];
    int         n;
    logic [7:0] b;
    logic [4:0] t;
    logic [1:0] idc;
    n = 0;
    b = it.data_byte;
    if (!in_packet) begin
      zeros_held  = '0;
      unit_live   = 1'b0;
      header_next = 1'b0;
      header_byte = '0;
      unit_len    = '0;
      idr_any     = 1'b0;
      slice_known = 1'b0;
      slice_idr   = 1'b0;
      prio_max    = it.initial_priority;
      in_packet   = 1'b1;
    end
    if (header_next) begin
      t = b[4:0];
      idc = b[6:5];
      header_next = 1'b0;
      unit_live   = 1'b1;
      header_byte = b;
      // a zero header also counts as a held zero
      if (b == ZERO_BYTE) begin
        unit_len   = '0;
        zeros_held = 2'd1;
      end else begin
        unit_len   = LENGTH_BITS'(1);
        zeros_held = '0;
      end
      if (idc > prio_max) prio_max = idc;
      if (t == TYPE_IDR) idr_any = 1'b1;
      if (!slice_known && (t == TYPE_IDR || t == TYPE_SLICE)) begin
        slice_known = 1'b1;
        slice_idr   = (t == TYPE_IDR);
      end
    end else if (b == ZERO_BYTE) begin
      if (zeros_held < ZERO_RUN_MAX) begin
        zeros_held = zeros_held + 2'd1;
      end else if (unit_live) begin
        unit_len = len_plus(unit_len, 1);
      end
    end else if (b == START_BYTE && zeros_held >= 2'd2) begin
      if (unit_live) begin
        recs[n] = unit_record(header_byte, unit_len);
        n++;
        unit_live = 1'b0;
      end
      header_next = 1'b1;
      zeros_held  = '0;
    end else begin
      if (unit_live) unit_len = len_plus(unit_len, 32'(zeros_held) + 32'd1);
      zeros_held = '0;
    end
    if (it.last_byte) begin
      // trailing zeros belong to a unit cut by the end of packet
      if (unit_live) begin
        recs[n] = unit_record(header_byte, len_plus(unit_len, 32'(zeros_held)));
        n++;
      end
      recs[n] = summary_record();
      n++;
      in_packet   = 1'b0;
      unit_live   = 1'b0;
      header_next = 1'b0;
      zeros_held  = '0;
      unit_len    = '0;
    end
    if (n > 0) recs[n-1].last_result = 1'b1;
    for (int i = 0; i < n; i++) records_due.push_back(recs[i]);
  endtask

  task automatic check_field(input string label, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, label, want_v, got_v);
      fail_tally = fail_tally + 1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (byte_valid && !byte_stall) scan_byte(byte_item);
      if (result_valid && !result_stall) begin
        if (records_due.size() == 0) begin
          $display("%0t: no record expected, got %h", $time, result_item);
          fail_tally = fail_tally + 1;
        end else begin
          want = records_due.pop_front();
          check_field("record_kind", 32'(want.record_kind), 32'(result_item.record_kind));
          check_field("unit_type", 32'(want.unit_type), 32'(result_item.unit_type));
          check_field("ref_importance", 32'(want.ref_importance),
                      32'(result_item.ref_importance));
          check_field("unit_class", 32'(want.unit_class), 32'(result_item.unit_class));
          check_field("unit_length", 32'(want.unit_length), 32'(result_item.unit_length));
          check_field("packet_priority", 32'(want.packet_priority),
                      32'(result_item.packet_priority));
          check_field("any_idr_seen", 32'(want.any_idr_seen),
                      32'(result_item.any_idr_seen));
          check_field("first_slice_idr", 32'(want.first_slice_idr),
                      32'(result_item.first_slice_idr));
          check_field("last_result", 32'(want.last_result), 32'(result_item.last_result));
        end
      end
    end
    records_pending <= records_due.size();
  end

endmodule

FILE: tb/annexb_nal_scanner_core_test.sv
`timescale 1ns / 1ps
// Top of the NAL scanner testbench: drives Annex B packets under several
// idle and stall mixes and reports the verdict. Depends on nalscan_pkg,
// nalscan_checker and annexb_nal_scanner_core.
module annexb_nal_scanner_core_test;
  import nalscan_pkg::*;

  localparam int LEN_BITS       = 24;
  localparam int ITEM_TARGET    = 1250;
  localparam int PHASE_ITEMS    = 150;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 8;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_stall;
  scan_in_t  byte_item = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  scan_out_t result_item;
  int        mismatches;
  int        records_pending;

  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         holdoff_len = 0;
  int         sent_items = 0;
  int         quiet_cycles = 0;
  logic [7:0] pkt_bytes[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  annexb_nal_scanner_core #(.LENGTH_BITS(LEN_BITS)) DUT (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

  nalscan_checker #(.LENGTH_BITS(LEN_BITS)) record_check (
    .clk             (clk),
    .rst             (rst),
    .byte_valid      (byte_valid),
    .byte_stall      (byte_stall),
    .byte_item       (byte_item),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .result_item     (result_item),
    .mismatches      (mismatches),
    .records_pending (records_pending)
  );

  // receiver: random stall, or a long hold-off when one is requested
  initial begin
    forever begin
      @(negedge clk);
      if (holdoff_len != 0) begin
        result_stall = 1'b1;
        repeat (holdoff_len - 1) @(negedge clk);
        holdoff_len = 0;
      end else begin
        result_stall = ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_byte(input scan_in_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid = 1'b0;
      byte_item  = scan_in_t'($urandom);
      @(negedge clk);
    end
    byte_valid = 1'b1;
    byte_item  = it;
    do @(posedge clk); while (byte_stall);
  endtask

  task automatic send_packet();
    scan_in_t it;
    for (int i = 0; i < pkt_bytes.size(); i++) begin
      it.data_byte        = pkt_bytes[i];
      it.last_byte        = (i == pkt_bytes.size() - 1);
      it.initial_priority = 2'($urandom_range(3));
      send_byte(it);
      sent_items++;
    end
  endtask

  // bias toward zero and one so start codes also form by chance
  function automatic logic [7:0] noisy_byte();
    logic [7:0] b;
    case ($urandom_range(9))
      0, 1, 2, 3: b = ZERO_BYTE;
      4:          b = START_BYTE;
      default:    b = 8'($urandom_range(255));
    endcase
    return b;
  endfunction

  task automatic add_start_code();
    if ($urandom_range(3) == 0) pkt_bytes.push_back(ZERO_BYTE);
    pkt_bytes.push_back(ZERO_BYTE);
    pkt_bytes.push_back(ZERO_BYTE);
    pkt_bytes.push_back(START_BYTE);
  endtask

  task automatic add_unit();
    logic [4:0] t;
    logic [1:0] idc;
    logic [7:0] hdr;
    int         len;
    add_start_code();
    case ($urandom_range(7))
      0:       t = TYPE_SLICE;
      1:       t = TYPE_IDR;
      2:       t = TYPE_SEI;
      3:       t = TYPE_SPS;
      4:       t = TYPE_PPS;
      default: t = 5'($urandom_range(31));
    endcase
    idc = 2'($urandom_range(3));
    hdr = {($urandom_range(15) == 0), idc, t};
    if ($urandom_range(19) == 0) hdr = ZERO_BYTE;
    pkt_bytes.push_back(hdr);
    len = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(10);
    repeat (len) pkt_bytes.push_back(noisy_byte());
    if ($urandom_range(4) == 0) repeat ($urandom_range(1, 5)) pkt_bytes.push_back(ZERO_BYTE);
  endtask

  task automatic build_packet();
    pkt_bytes.delete();
    if ($urandom_range(9) < 2) begin
      // noise and broken packets
      repeat ($urandom_range(1, 20)) pkt_bytes.push_back(noisy_byte());
    end else begin
      repeat ($urandom_range(2)) pkt_bytes.push_back(noisy_byte());
      repeat ($urandom_range(1, 5)) add_unit();
      if ($urandom_range(7) == 0) add_start_code();
    end
  endtask

  initial begin
    int phase;
    int phase_end;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // junk prefix, forbidden bit, zero header, long zero run, cut unit with zeros
    pkt_bytes = {8'h55, 8'h00, 8'h00, 8'h01, 8'hE5, 8'hAA, 8'h00, 8'h00, 8'h00,
                 8'h00, 8'h00, 8'h12, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00,
                 8'h01, 8'h67, 8'hFF, 8'h00, 8'h00};
    send_packet();
    // start code ends the packet, no slices
    pkt_bytes = {8'h00, 8'h00, 8'h01};
    send_packet();

    phase = 0;
    while (sent_items < ITEM_TARGET) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      if (phase == 4) holdoff_len = HOLDOFF_CYCLES;
      phase_end = sent_items + PHASE_ITEMS;
      while (sent_items < phase_end && sent_items < ITEM_TARGET) begin
        build_packet();
        send_packet();
      end
      phase++;
    end

    @(negedge clk);
    byte_valid = 1'b0;
    while (records_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/nalscan_pkg.sv
sv/nalscan_step.sv
sv/nalscan_queue.sv
sv/annexb_nal_scanner_core.sv
tb/nalscan_checker.sv
tb/annexb_nal_scanner_core_test.sv
